@@ rtl/bpa_pkg.sv @@
// Shared types, codes and default sizes for the block pool allocator.
// Used by the channel interfaces, the flag memory, the divider and the top level.
`default_nettype none

package bpa_pkg;

    // Payload field widths fixed by the channel format.
    localparam int SIZE_W = 20;
    localparam int IDX_W  = 8;
    localparam int CNT_W  = 9;
    localparam int FB_W   = 16;

    // Defaults for the top-level parameters.
    localparam int DEF_NUM_BLOCKS  = 256;
    localparam int DEF_BLOCK_BYTES = 64;

    typedef logic [SIZE_W-1:0] t_size;
    typedef logic [IDX_W-1:0]  t_idx;
    typedef logic [CNT_W-1:0]  t_cnt;
    typedef logic [FB_W-1:0]   t_fb;

    localparam t_fb FB_MAX = '1;

    localparam logic MODE_ALLOC = 1'b0;
    localparam logic MODE_FREE  = 1'b1;

    typedef enum logic [1:0] {
        ST_POOL_ALLOC = 2'd0,
        ST_FB_ALLOC   = 2'd1,
        ST_POOL_FREE  = 2'd2,
        ST_FB_FREE    = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        FL_FREE = 2'd0,
        FL_HEAD = 2'd1,
        FL_BODY = 2'd2
    } t_flag;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_DIV,
        S_DEC,
        S_ONE_CHK,
        S_DOWN,
        S_FIT,
        S_MARK,
        S_HI_RD,
        S_UP,
        S_FR_HEAD,
        S_FR_BODY,
        S_EMIT
    } t_state;

endpackage

`default_nettype wire

@@ rtl/bpa_if.sv @@
// Valid/ready channel interfaces for allocator requests and responses.
// Depends on bpa_pkg for the payload types.
`default_nettype none

interface bpa_req_if;
    logic               valid;
    logic               ready;
    logic               mode;
    bpa_pkg::t_size     size_bytes;
    bpa_pkg::t_idx      block_index;
    logic               outside_pool;

    modport source (output valid, mode, size_bytes, block_index, outside_pool, input ready);
    modport sink   (input valid, mode, size_bytes, block_index, outside_pool, output ready);
endinterface

interface bpa_rsp_if;
    logic               valid;
    logic               ready;
    bpa_pkg::t_status   status;
    bpa_pkg::t_idx      head_index;
    bpa_pkg::t_cnt      blocks_changed;
    bpa_pkg::t_cnt      blocks_free;
    bpa_pkg::t_fb       fallback_outstanding;

    modport source (output valid, status, head_index, blocks_changed, blocks_free,
                    fallback_outstanding, input ready);
    modport sink   (input valid, status, head_index, blocks_changed, blocks_free,
                    fallback_outstanding, output ready);
endinterface

`default_nettype wire

@@ rtl/bpa_flag_ram.sv @@
// Block flag map: one write port and one read port with registered read data.
// Depends on bpa_pkg for the flag type.
`default_nettype none

module bpa_flag_ram #(
    parameter int DEPTH = bpa_pkg::DEF_NUM_BLOCKS
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire bpa_pkg::t_flag           i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output bpa_pkg::t_flag                o_rdata
);

    bpa_pkg::t_flag mem [DEPTH];
    bpa_pkg::t_flag r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

@@ rtl/bpa_div.sv @@
// Division of the request size by a constant block size through reciprocal multiplication.
// Depends on bpa_pkg for the dividend width.
`default_nettype none

module bpa_div #(
    parameter int DIVISOR = bpa_pkg::DEF_BLOCK_BYTES
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_start,
    input  wire bpa_pkg::t_size i_dividend,
    output logic                o_done,
    output bpa_pkg::t_size      o_quotient
);

    // With L = ceil(log2(DIVISOR)) and M = ceil(2^(SIZE_W+L) / DIVISOR), the error
    // M*DIVISOR - 2^(SIZE_W+L) stays below 2^L, so (x*M) >> (SIZE_W+L) is exact for
    // every SIZE_W-bit dividend. M never exceeds 2^(SIZE_W+1).
    localparam int L  = $clog2(DIVISOR);
    localparam int SH = bpa_pkg::SIZE_W + L;
    localparam int MW = bpa_pkg::SIZE_W + 2;
    localparam int PW = bpa_pkg::SIZE_W + MW;
    localparam longint unsigned MUL = ((64'd1 << SH) + 64'(DIVISOR) - 64'd1) / 64'(DIVISOR);
    localparam logic [MW-1:0] MUL_C = MW'(MUL);

    logic           r_done, n_done;
    bpa_pkg::t_size r_quo, n_quo;
    logic [PW-1:0]  prod;
    bpa_pkg::t_size quo;

    assign prod = PW'(i_dividend) * PW'(MUL_C);
    assign quo  = bpa_pkg::t_size'(prod >> SH);

    always_comb begin
        n_done = i_start;
        n_quo  = i_start ? quo : r_quo;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_quo <= n_quo;
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule

`default_nettype wire

@@ rtl/block_pool_allocator.sv @@
// Block pool allocator top level: sequencer, pool bookkeeping and response register.
// Depends on bpa_pkg, bpa_if, bpa_flag_ram and bpa_div.
//
// Channel   Dir  Handshake     Payload
// i_req     in   valid/ready   mode, size_bytes, block_index, outside_pool
// o_rsp     out  valid/ready   status, head_index, blocks_changed, blocks_free,
//                              fallback_outstanding
//
// After reset the flag memory is cleared one entry per cycle, and no request is
// taken until that pass ends.
// A fallback free only updates the outstanding count. A pooled free checks the head
// flag, then releases the body blocks walking upward; an ignored free releases nothing.
// An allocation first passes through the divider (skipped for a zero size), then walks
// the flag memory one entry per cycle through its single read port; the first-fit walk
// and the walk that moves the lowest free index together cover the map at most once.
// Requests are taken one at a time; a finished response waits in the output register
// while the next request is already accepted and processed.
`default_nettype none

module block_pool_allocator #(
    parameter int NUM_BLOCKS  = bpa_pkg::DEF_NUM_BLOCKS,
    parameter int BLOCK_BYTES = bpa_pkg::DEF_BLOCK_BYTES
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    bpa_req_if.sink    i_req,
    bpa_rsp_if.source  o_rsp
);

    // Index width for the flag memory and count width that can also hold "none".
    localparam int IW = $clog2(NUM_BLOCKS);
    localparam int CW = $clog2(NUM_BLOCKS + 1);
    localparam int NW = bpa_pkg::SIZE_W + 1;

    localparam logic [IW-1:0] LAST = IW'(NUM_BLOCKS - 1);
    localparam logic [CW-1:0] NONE = CW'(NUM_BLOCKS);
    localparam logic [CW-1:0] ONE  = CW'(1);

    bpa_pkg::t_state r_state, n_state;

    // Pool bookkeeping. Lowest and highest free hold NONE when there is no free block.
    logic [CW-1:0]  r_free, n_free;
    logic [CW-1:0]  r_low,  n_low;
    logic [CW-1:0]  r_high, n_high;
    bpa_pkg::t_fb   r_fb,   n_fb;

    // Working registers of the current request.
    logic [IW-1:0]  r_addr,  n_addr;
    logic [IW-1:0]  r_begin, n_begin;
    logic [IW-1:0]  r_end,   n_end;
    logic [CW-1:0]  r_run,   n_run;
    logic [CW-1:0]  r_need,  n_need;
    logic           r_zero,  n_zero;
    logic [IW-1:0]  r_head,  n_head;
    logic [CW-1:0]  r_changed, n_changed;
    bpa_pkg::t_status r_res_status, n_res_status;

    // Response register.
    logic             r_ovalid, n_ovalid;
    bpa_pkg::t_status r_o_status, n_o_status;
    bpa_pkg::t_idx    r_o_head, n_o_head;
    bpa_pkg::t_cnt    r_o_changed, n_o_changed;
    bpa_pkg::t_cnt    r_o_free, n_o_free;
    bpa_pkg::t_fb     r_o_fb, n_o_fb;

    // Flag memory port.
    logic           mem_we;
    logic [IW-1:0]  mem_waddr;
    bpa_pkg::t_flag mem_wdata;
    logic           mem_re;
    logic [IW-1:0]  mem_raddr;
    bpa_pkg::t_flag rd_flag;

    // Divider.
    logic           div_start;
    bpa_pkg::t_size div_dividend;
    logic           div_done;
    bpa_pkg::t_size div_quo;

    // Sequencer events resolved after the state case.
    logic           go_fb;
    logic           go_done;
    logic           go_after_down;
    logic           go_low;
    logic           go_fin;
    logic [IW-1:0]  fin_j;

    logic [NW-1:0]  need_full;
    logic [CW-1:0]  run_next;

    bpa_flag_ram #(
        .DEPTH   (NUM_BLOCKS)
    ) u_flags (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_re    (mem_re),
        .i_raddr (mem_raddr),
        .o_rdata (rd_flag)
    );

    bpa_div #(
        .DIVISOR    (BLOCK_BYTES)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_dividend),
        .o_done     (div_done),
        .o_quotient (div_quo)
    );

    // Blocks needed: ceil(size / BLOCK_BYTES) = floor((size - 1) / BLOCK_BYTES) + 1,
    // and a zero size counts as one block.
    assign need_full    = r_zero ? NW'(1) : (NW'(div_quo) + NW'(1));
    assign run_next     = (rd_flag == bpa_pkg::FL_FREE) ? (r_run + ONE) : '0;
    assign div_dividend = i_req.size_bytes - bpa_pkg::t_size'(1);

    always_comb begin
        n_state      = r_state;
        n_free       = r_free;
        n_low        = r_low;
        n_high       = r_high;
        n_fb         = r_fb;
        n_addr       = r_addr;
        n_begin      = r_begin;
        n_end        = r_end;
        n_run        = r_run;
        n_need       = r_need;
        n_zero       = r_zero;
        n_head       = r_head;
        n_changed    = r_changed;
        n_res_status = r_res_status;

        n_ovalid     = r_ovalid & ~o_rsp.ready;
        n_o_status   = r_o_status;
        n_o_head     = r_o_head;
        n_o_changed  = r_o_changed;
        n_o_free     = r_o_free;
        n_o_fb       = r_o_fb;

        mem_we       = 1'b0;
        mem_waddr    = r_addr;
        mem_wdata    = bpa_pkg::FL_FREE;
        mem_re       = 1'b0;
        mem_raddr    = r_addr;
        div_start    = 1'b0;

        go_fb         = 1'b0;
        go_done       = 1'b0;
        go_after_down = 1'b0;
        go_low        = 1'b0;
        go_fin        = 1'b0;
        fin_j         = r_addr;

        unique case (r_state)
            bpa_pkg::S_CLEAR: begin
                // Write every entry free once after reset.
                mem_we = 1'b1;
                n_addr = r_addr + IW'(1);
                if (r_addr == LAST) begin
                    n_state = bpa_pkg::S_IDLE;
                end
            end

            bpa_pkg::S_IDLE: begin
                if (i_req.valid) begin
                    n_head    = '0;
                    n_changed = '0;
                    if (i_req.mode == bpa_pkg::MODE_ALLOC) begin
                        if (i_req.size_bytes == '0) begin
                            n_zero  = 1'b1;
                            n_state = bpa_pkg::S_DEC;
                        end else begin
                            n_zero    = 1'b0;
                            div_start = 1'b1;
                            n_state   = bpa_pkg::S_DIV;
                        end
                    end else if (i_req.outside_pool) begin
                        // Fallback free only touches the outstanding count.
                        if (r_fb != '0) begin
                            n_fb = r_fb - bpa_pkg::t_fb'(1);
                        end
                        n_res_status = bpa_pkg::ST_FB_FREE;
                        n_state      = bpa_pkg::S_EMIT;
                    end else begin
                        n_res_status = bpa_pkg::ST_POOL_FREE;
                        if (32'(i_req.block_index) < 32'(NUM_BLOCKS)) begin
                            mem_re    = 1'b1;
                            mem_raddr = IW'(i_req.block_index);
                            n_addr    = IW'(i_req.block_index);
                            n_state   = bpa_pkg::S_FR_HEAD;
                        end else begin
                            n_state = bpa_pkg::S_EMIT;
                        end
                    end
                end
            end

            bpa_pkg::S_DIV: begin
                if (div_done) begin
                    n_state = bpa_pkg::S_DEC;
                end
            end

            bpa_pkg::S_DEC: begin
                n_need = CW'(need_full);
                if (need_full > NW'(r_free)) begin
                    go_fb = 1'b1;
                end else if (need_full == NW'(1)) begin
                    // Single block: try the highest free index.
                    if (r_high == NONE) begin
                        go_fb = 1'b1;
                    end else begin
                        mem_re    = 1'b1;
                        mem_raddr = IW'(r_high);
                        n_state   = bpa_pkg::S_ONE_CHK;
                    end
                end else begin
                    // First fit, scanning upward from the lowest free index.
                    if (r_low == NONE) begin
                        go_fb = 1'b1;
                    end else begin
                        mem_re    = 1'b1;
                        mem_raddr = IW'(r_low);
                        n_addr    = IW'(r_low);
                        n_run     = '0;
                        n_state   = bpa_pkg::S_FIT;
                    end
                end
            end

            bpa_pkg::S_ONE_CHK: begin
                if (rd_flag == bpa_pkg::FL_FREE) begin
                    mem_we    = 1'b1;
                    mem_waddr = IW'(r_high);
                    mem_wdata = bpa_pkg::FL_HEAD;
                    n_head    = IW'(r_high);
                    n_free    = r_free - ONE;
                    if (r_free == ONE) begin
                        n_low   = NONE;
                        n_high  = NONE;
                        go_done = 1'b1;
                    end else if (r_high == '0) begin
                        n_high  = NONE;
                        go_done = 1'b1;
                    end else begin
                        mem_re    = 1'b1;
                        mem_raddr = IW'(r_high - ONE);
                        n_addr    = IW'(r_high - ONE);
                        n_state   = bpa_pkg::S_DOWN;
                    end
                end else begin
                    go_fb = 1'b1;
                end
            end

            bpa_pkg::S_DOWN: begin
                // Read data belongs to r_addr; the next lower entry is requested when this one is not free.
                if (rd_flag == bpa_pkg::FL_FREE) begin
                    n_high        = CW'(r_addr);
                    go_after_down = 1'b1;
                end else if (r_addr == '0) begin
                    n_high        = NONE;
                    go_after_down = 1'b1;
                end else begin
                    mem_re    = 1'b1;
                    mem_raddr = r_addr - IW'(1);
                    n_addr    = r_addr - IW'(1);
                end
            end

            bpa_pkg::S_FIT: begin
                if (run_next == r_need) begin
                    n_end   = r_addr;
                    n_begin = IW'(CW'(r_addr) + ONE - r_need);
                    n_addr  = IW'(CW'(r_addr) + ONE - r_need);
                    n_state = bpa_pkg::S_MARK;
                end else if (r_addr == LAST) begin
                    go_fb = 1'b1;
                end else begin
                    n_run     = run_next;
                    mem_re    = 1'b1;
                    mem_raddr = r_addr + IW'(1);
                    n_addr    = r_addr + IW'(1);
                end
            end

            bpa_pkg::S_MARK: begin
                // Head flag on the first block of the run, body flags on the rest.
                mem_we    = 1'b1;
                mem_waddr = r_addr;
                mem_wdata = (r_addr == r_begin) ? bpa_pkg::FL_HEAD : bpa_pkg::FL_BODY;
                if (r_addr == r_end) begin
                    n_head = r_begin;
                    n_free = r_free - r_need;
                    if (r_free == r_need) begin
                        n_low   = NONE;
                        n_high  = NONE;
                        go_done = 1'b1;
                    end else begin
                        n_state = bpa_pkg::S_HI_RD;
                    end
                end else begin
                    n_addr = r_addr + IW'(1);
                end
            end

            bpa_pkg::S_HI_RD: begin
                // Recheck the highest free index; the downward walk keeps it if still free.
                mem_re = 1'b1;
                if (r_high == NONE) begin
                    mem_raddr = LAST;
                    n_addr    = LAST;
                end else begin
                    mem_raddr = IW'(r_high);
                    n_addr    = IW'(r_high);
                end
                n_state = bpa_pkg::S_DOWN;
            end

            bpa_pkg::S_UP: begin
                if (rd_flag == bpa_pkg::FL_FREE) begin
                    n_low   = CW'(r_addr);
                    go_done = 1'b1;
                end else if (r_addr == LAST) begin
                    n_low   = NONE;
                    go_done = 1'b1;
                end else begin
                    mem_re    = 1'b1;
                    mem_raddr = r_addr + IW'(1);
                    n_addr    = r_addr + IW'(1);
                end
            end

            bpa_pkg::S_FR_HEAD: begin
                if (rd_flag == bpa_pkg::FL_HEAD) begin
                    if (CW'(r_addr) < r_low) begin
                        n_low = CW'(r_addr);
                    end
                    mem_we    = 1'b1;
                    mem_waddr = r_addr;
                    n_changed = ONE;
                    if (r_addr == LAST) begin
                        go_fin = 1'b1;
                        fin_j  = r_addr;
                    end else begin
                        mem_re    = 1'b1;
                        mem_raddr = r_addr + IW'(1);
                        n_addr    = r_addr + IW'(1);
                        n_state   = bpa_pkg::S_FR_BODY;
                    end
                end else begin
                    // Not a head block: the free is ignored.
                    n_state = bpa_pkg::S_EMIT;
                end
            end

            bpa_pkg::S_FR_BODY: begin
                if (rd_flag == bpa_pkg::FL_BODY) begin
                    mem_we    = 1'b1;
                    mem_waddr = r_addr;
                    n_changed = r_changed + ONE;
                    if (r_addr == LAST) begin
                        go_fin = 1'b1;
                        fin_j  = r_addr;
                    end else begin
                        mem_re    = 1'b1;
                        mem_raddr = r_addr + IW'(1);
                        n_addr    = r_addr + IW'(1);
                    end
                end else begin
                    go_fin = 1'b1;
                    fin_j  = r_addr - IW'(1);
                end
            end

            bpa_pkg::S_EMIT: begin
                if (!r_ovalid || o_rsp.ready) begin
                    n_ovalid    = 1'b1;
                    n_o_status  = r_res_status;
                    n_o_head    = bpa_pkg::t_idx'(r_head);
                    n_o_changed = bpa_pkg::t_cnt'(r_changed);
                    n_o_free    = bpa_pkg::t_cnt'(r_free);
                    n_o_fb      = r_fb;
                    n_state     = bpa_pkg::S_IDLE;
                end
            end

            default: begin
                n_state = bpa_pkg::S_IDLE;
            end
        endcase

        // After the downward walk, a one-block request is finished; a larger one
        // may still have to move the lowest free index past the new run.
        if (go_after_down) begin
            if (r_need == ONE) begin
                go_done = 1'b1;
            end else begin
                go_low = 1'b1;
            end
        end

        if (go_low) begin
            if (CW'(r_begin) == r_low) begin
                if (r_end == LAST) begin
                    n_low   = NONE;
                    go_done = 1'b1;
                end else begin
                    mem_re    = 1'b1;
                    mem_raddr = r_end + IW'(1);
                    n_addr    = r_end + IW'(1);
                    n_state   = bpa_pkg::S_UP;
                end
            end else begin
                go_done = 1'b1;
            end
        end

        if (go_done) begin
            n_res_status = bpa_pkg::ST_POOL_ALLOC;
            n_changed    = r_need;
            n_state      = bpa_pkg::S_EMIT;
        end

        if (go_fb) begin
            if (r_fb != bpa_pkg::FB_MAX) begin
                n_fb = r_fb + bpa_pkg::t_fb'(1);
            end
            n_res_status = bpa_pkg::ST_FB_ALLOC;
            n_head       = '0;
            n_changed    = '0;
            n_state      = bpa_pkg::S_EMIT;
        end

        // End of a pooled free: fin_j is the last block released.
        if (go_fin) begin
            n_free = r_free + n_changed;
            if (r_high == NONE || CW'(fin_j) > r_high) begin
                n_high = CW'(fin_j);
            end
            n_state = bpa_pkg::S_EMIT;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= bpa_pkg::S_CLEAR;
            r_addr   <= '0;
            r_free   <= NONE;
            r_low    <= '0;
            r_high   <= CW'(LAST);
            r_fb     <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_addr   <= n_addr;
            r_free   <= n_free;
            r_low    <= n_low;
            r_high   <= n_high;
            r_fb     <= n_fb;
            r_ovalid <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_begin      <= n_begin;
        r_end        <= n_end;
        r_run        <= n_run;
        r_need       <= n_need;
        r_zero       <= n_zero;
        r_head       <= n_head;
        r_changed    <= n_changed;
        r_res_status <= n_res_status;
        r_o_status   <= n_o_status;
        r_o_head     <= n_o_head;
        r_o_changed  <= n_o_changed;
        r_o_free     <= n_o_free;
        r_o_fb       <= n_o_fb;
    end

    assign i_req.ready                = (r_state == bpa_pkg::S_IDLE);
    assign o_rsp.valid                = r_ovalid;
    assign o_rsp.status               = r_o_status;
    assign o_rsp.head_index           = r_o_head;
    assign o_rsp.blocks_changed       = r_o_changed;
    assign o_rsp.blocks_free          = r_o_free;
    assign o_rsp.fallback_outstanding = r_o_fb;

endmodule

`default_nettype wire
